[src/homography_segment_projection_top_defines.svh]
// Assertion macros shared by the projection block
`ifndef HOMOGRAPHY_SEGMENT_PROJECTION_TOP_DEFINES_SVH
`define HOMOGRAPHY_SEGMENT_PROJECTION_TOP_DEFINES_SVH

// same-cycle implication
`define HSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication after a fixed delay
`define HSP_ASSERT_AFTER(label, clk, rst, ante, dly, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
      else $error(msg);

`endif

[src/hsp_pkg.sv]
// ----------------------------------------------------------------------------
// hsp_pkg
// Types and register codes of the segment projection block.
// ----------------------------------------------------------------------------
`default_nettype none
package hsp_pkg;

   localparam int FIELD_W = 32;
   localparam int CSR_W = 64;
   localparam int CSR_IDX_W = 3;
   localparam int FRAC_SHIFT = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_B = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_C = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_D = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST = 3'd4;

   localparam logic [CSR_W-1:0] COEF_ONE = 64'd1048576;

   typedef struct packed {
      logic signed [FIELD_W-1:0] first_x;
      logic signed [FIELD_W-1:0] first_y;
      logic signed [FIELD_W-1:0] first_w;
      logic signed [FIELD_W-1:0] second_x;
      logic signed [FIELD_W-1:0] second_y;
      logic signed [FIELD_W-1:0] second_w;
   } hsp_req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] out_first_x;
      logic signed [FIELD_W-1:0] out_first_y;
      logic signed [FIELD_W-1:0] out_second_x;
      logic signed [FIELD_W-1:0] out_second_y;
      logic in_front;
      logic clipped;
   } hsp_rsp_type;

   // control that rides along the divider chain
   typedef struct packed {
      logic vld;
      logic in_front;
   } hsp_ctl_type;

endpackage
`default_nettype wire

[src/hsp_point_proj.sv]
// ----------------------------------------------------------------------------
// hsp_point_proj
// One point times the 3x3 matrix: products, then row sums, both registered.
// ----------------------------------------------------------------------------
`default_nettype none
module hsp_point_proj #(
   parameter int COEF_W = 32,
   parameter int IN_W = 32,
   parameter int SUM_W = COEF_W + IN_W + 2
) (
   input  wire logic clock,
   input  wire logic signed [COEF_W-1:0] coef [9],
   input  wire logic signed [IN_W-1:0] pt_x,
   input  wire logic signed [IN_W-1:0] pt_y,
   input  wire logic signed [IN_W-1:0] pt_w,
   output logic signed [SUM_W-1:0] proj_x,
   output logic signed [SUM_W-1:0] proj_y,
   output logic signed [SUM_W-1:0] proj_w
);
   localparam int PROD_W = COEF_W + IN_W;

   logic signed [PROD_W-1:0] prod_ff [9];
   logic signed [PROD_W-1:0] prod_in [9];
   logic signed [SUM_W-1:0] sum_ff [3];
   logic signed [SUM_W-1:0] sum_in [3];
   logic signed [IN_W-1:0] pt [3];

   always_comb begin
      pt[0] = pt_x;
      pt[1] = pt_y;
      pt[2] = pt_w;
      for (int k = 0; k < 9; k++) begin
         prod_in[k] = PROD_W'(coef[k]) * PROD_W'(pt[k % 3]);
      end
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = SUM_W'(prod_ff[r*3]) + SUM_W'(prod_ff[r*3+1])
                     + SUM_W'(prod_ff[r*3+2]);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff <= sum_in;
   end

   assign proj_x = sum_ff[0];
   assign proj_y = sum_ff[1];
   assign proj_w = sum_ff[2];
endmodule
`default_nettype wire

[src/hsp_div_cell.sv]
// ----------------------------------------------------------------------------
// hsp_div_cell
// One restoring-division step: one quotient bit per cell, registered.
// ----------------------------------------------------------------------------
`default_nettype none
module hsp_div_cell #(
   parameter int SUM_W = 66,
   parameter int QUO_W = 32
) (
   input  wire logic clock,
   input  wire logic [SUM_W-1:0] rem_i,
   input  wire logic [QUO_W-1:0] num_i,
   input  wire logic [QUO_W-1:0] quo_i,
   input  wire logic [SUM_W-1:0] den_i,
   input  wire logic neg_i,
   input  wire logic ovf_i,
   output logic [SUM_W-1:0] rem_o,
   output logic [QUO_W-1:0] num_o,
   output logic [QUO_W-1:0] quo_o,
   output logic [SUM_W-1:0] den_o,
   output logic neg_o,
   output logic ovf_o
);
   logic [SUM_W:0] part;
   logic ge;
   logic [SUM_W:0] diff;
   logic [SUM_W-1:0] rem_in;

   always_comb begin
      part = {rem_i, num_i[QUO_W-1]};
      ge = part >= {1'b0, den_i};
      diff = part - {1'b0, den_i};
      rem_in = ge ? diff[SUM_W-1:0] : part[SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      rem_o <= rem_in;
      num_o <= {num_i[QUO_W-2:0], 1'b0};
      quo_o <= {quo_i[QUO_W-2:0], ge};
      den_o <= den_i;
      neg_o <= neg_i;
      ovf_o <= ovf_i;
   end
endmodule
`default_nettype wire

[src/homography_segment_projection_top.sv]
// ----------------------------------------------------------------------------
// homography_segment_projection_top
// Projects a segment (two homogeneous points) through a 3x3 homography.
// ----------------------------------------------------------------------------
//  port group  | dir | handshake               | payload
//  req_        | in  | start & !busy           | req_item (hsp_req_type)
//  rsp_        | out | rsp_strobe, one cycle   | rsp_item (hsp_rsp_type)
//  csr_        | in  | csr_we, no wait         | csr_index, csr_wdata
//
//  One item per cycle; busy is held low, so start is always taken.
//  Path from accept to strobe: capture, products, row sums, divider
//  setup, the chain of IN_BITS division cells (one quotient bit per
//  cell, four lanes) and the output register.
//  Synchronous active-high reset clears the valid chain and loads the
//  identity matrix. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
`default_nettype none
module homography_segment_projection_top #(
   parameter int COORD_WIDTH = 32,
   parameter int COEF_WIDTH = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire hsp_pkg::hsp_req_type req_item,
   output logic rsp_strobe,
   output hsp_pkg::hsp_rsp_type rsp_item,
   input  wire logic csr_we,
   input  wire logic [hsp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [hsp_pkg::CSR_W-1:0] csr_wdata
);
   import hsp_pkg::*;
`include "homography_segment_projection_top_defines.svh"

   localparam int IN_BITS = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam int SUM_W = COEF_WIDTH + IN_BITS + 2;
   localparam int NUM_W = SUM_W + FRAC_SHIFT;
   localparam int LAT = IN_BITS + 5;

   // ---- coefficient registers ----
   logic [CSR_W-1:0] pair_a_ff, pair_b_ff, pair_c_ff, pair_d_ff;
   logic [FIELD_W-1:0] last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_a_ff <= COEF_ONE;
         pair_b_ff <= '0;
         pair_c_ff <= COEF_ONE;
         pair_d_ff <= '0;
         last_ff <= COEF_ONE[FIELD_W-1:0];
      end else if (csr_we) begin
         case (csr_index)
            CSR_PAIR_A: pair_a_ff <= csr_wdata;
            CSR_PAIR_B: pair_b_ff <= csr_wdata;
            CSR_PAIR_C: pair_c_ff <= csr_wdata;
            CSR_PAIR_D: pair_d_ff <= csr_wdata;
            CSR_LAST: last_ff <= csr_wdata[FIELD_W-1:0];
            default: ;
         endcase
      end
   end

   // each coefficient: low COEF_WIDTH bits of its 32-bit slot
   logic signed [COEF_WIDTH-1:0] coef [9];
   always_comb begin
      coef[0] = pair_a_ff[COEF_WIDTH-1:0];
      coef[1] = pair_a_ff[32+COEF_WIDTH-1:32];
      coef[2] = pair_b_ff[COEF_WIDTH-1:0];
      coef[3] = pair_b_ff[32+COEF_WIDTH-1:32];
      coef[4] = pair_c_ff[COEF_WIDTH-1:0];
      coef[5] = pair_c_ff[32+COEF_WIDTH-1:32];
      coef[6] = pair_d_ff[COEF_WIDTH-1:0];
      coef[7] = pair_d_ff[32+COEF_WIDTH-1:32];
      coef[8] = last_ff[COEF_WIDTH-1:0];
   end

   assign busy = 1'b0;
   logic accept;
   assign accept = start && !busy;

   // ---- stage 0: capture the item ----
   logic signed [IN_BITS-1:0] pt_ff [6];
   always_ff @(posedge clock) begin
      if (accept) begin
         pt_ff[0] <= req_item.first_x[IN_BITS-1:0];
         pt_ff[1] <= req_item.first_y[IN_BITS-1:0];
         pt_ff[2] <= req_item.first_w[IN_BITS-1:0];
         pt_ff[3] <= req_item.second_x[IN_BITS-1:0];
         pt_ff[4] <= req_item.second_y[IN_BITS-1:0];
         pt_ff[5] <= req_item.second_w[IN_BITS-1:0];
      end
   end

   // valid through capture, products and sums
   logic [2:0] head_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= '0;
      end else begin
         head_vld_ff <= {head_vld_ff[1:0], accept};
      end
   end

   // ---- stages 1-2: matrix products and row sums ----
   logic signed [SUM_W-1:0] px [2], py [2], pw [2];
   for (genvar p = 0; p < 2; p++) begin : g_pt
      hsp_point_proj #(.COEF_W(COEF_WIDTH), .IN_W(IN_BITS), .SUM_W(SUM_W)) u_proj (
         .clock(clock), .coef(coef),
         .pt_x(pt_ff[p*3]), .pt_y(pt_ff[p*3+1]), .pt_w(pt_ff[p*3+2]),
         .proj_x(px[p]), .proj_y(py[p]), .proj_w(pw[p])
      );
   end

   // ---- stage 3: magnitude, overflow test, divider setup ----
   // lanes: 0 first x, 1 first y, 2 second x, 3 second y
   hsp_ctl_type ctl_ff [IN_BITS+1];

   logic signed [SUM_W-1:0] lane_num [4];
   logic [SUM_W-1:0] lane_den [4];
   logic [SUM_W-1:0] lane_mag [4];
   logic [NUM_W-1:0] lane_n [4];
   logic [NUM_W-1:0] lane_hi [4];
   logic front_now;

   always_comb begin
      lane_num[0] = px[0];
      lane_num[1] = py[0];
      lane_num[2] = px[1];
      lane_num[3] = py[1];
      front_now = !pw[0][SUM_W-1] && (pw[0] != '0) && !pw[1][SUM_W-1] && (pw[1] != '0);
      for (int l = 0; l < 4; l++) begin
         lane_den[l] = pw[l/2];
         lane_mag[l] = lane_num[l][SUM_W-1] ? (SUM_W)'(-lane_num[l]) : lane_num[l];
         lane_n[l] = {lane_mag[l], {FRAC_SHIFT{1'b0}}};
         lane_hi[l] = lane_n[l] >> IN_BITS;
      end
   end

   logic [SUM_W-1:0] rem0_ff [4];
   logic [IN_BITS-1:0] num0_ff [4];
   logic [SUM_W-1:0] den0_ff [4];
   logic neg0_ff [4];
   logic ovf0_ff [4];

   always_ff @(posedge clock) begin
      for (int l = 0; l < 4; l++) begin
         rem0_ff[l] <= lane_hi[l][SUM_W-1:0];
         num0_ff[l] <= lane_n[l][IN_BITS-1:0];
         den0_ff[l] <= lane_den[l];
         neg0_ff[l] <= lane_num[l][SUM_W-1];
         // quotient needs more than IN_BITS bits
         ovf0_ff[l] <= lane_hi[l] >= NUM_W'(lane_den[l]);
      end
   end

   // control chain alongside the cells
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= IN_BITS; s++) begin
            ctl_ff[s].vld <= 1'b0;
         end
      end else begin
         ctl_ff[0].vld <= head_vld_ff[2];
         for (int s = 1; s <= IN_BITS; s++) begin
            ctl_ff[s].vld <= ctl_ff[s-1].vld;
         end
      end
      ctl_ff[0].in_front <= front_now;
      for (int s = 1; s <= IN_BITS; s++) begin
         ctl_ff[s].in_front <= ctl_ff[s-1].in_front;
      end
   end

   // ---- stages 4..: row of division cells, four lanes ----
   logic [SUM_W-1:0] rem_w [4][IN_BITS+1];
   logic [IN_BITS-1:0] num_w [4][IN_BITS+1];
   logic [IN_BITS-1:0] quo_w [4][IN_BITS+1];
   logic [SUM_W-1:0] den_w [4][IN_BITS+1];
   logic neg_w [4][IN_BITS+1];
   logic ovf_w [4][IN_BITS+1];

   for (genvar l = 0; l < 4; l++) begin : g_lane
      assign rem_w[l][0] = rem0_ff[l];
      assign num_w[l][0] = num0_ff[l];
      assign quo_w[l][0] = '0;
      assign den_w[l][0] = den0_ff[l];
      assign neg_w[l][0] = neg0_ff[l];
      assign ovf_w[l][0] = ovf0_ff[l];
      for (genvar s = 0; s < IN_BITS; s++) begin : g_cell
         hsp_div_cell #(.SUM_W(SUM_W), .QUO_W(IN_BITS)) u_cell (
            .clock(clock),
            .rem_i(rem_w[l][s]), .num_i(num_w[l][s]), .quo_i(quo_w[l][s]),
            .den_i(den_w[l][s]), .neg_i(neg_w[l][s]), .ovf_i(ovf_w[l][s]),
            .rem_o(rem_w[l][s+1]), .num_o(num_w[l][s+1]), .quo_o(quo_w[l][s+1]),
            .den_o(den_w[l][s+1]), .neg_o(neg_w[l][s+1]), .ovf_o(ovf_w[l][s+1])
         );
      end
   end

   // ---- output stage: saturate, sign, zero when behind ----
   logic [IN_BITS-1:0] lim [4];
   logic [IN_BITS-1:0] qs [4];
   logic [IN_BITS-1:0] qv [4];
   logic sat [4];
   logic signed [FIELD_W-1:0] res [4];
   logic any_sat;
   logic front_out;
   hsp_rsp_type rsp_in;

   always_comb begin
      any_sat = 1'b0;
      front_out = ctl_ff[IN_BITS].in_front;
      for (int l = 0; l < 4; l++) begin
         lim[l] = {neg_w[l][IN_BITS], {(IN_BITS-1){!neg_w[l][IN_BITS]}}};
         sat[l] = ovf_w[l][IN_BITS] || (quo_w[l][IN_BITS] > lim[l]);
         qs[l] = sat[l] ? lim[l] : quo_w[l][IN_BITS];
         qv[l] = neg_w[l][IN_BITS] ? (IN_BITS)'(-qs[l]) : qs[l];
         res[l] = front_out ? FIELD_W'(signed'(qv[l])) : '0;
         any_sat = any_sat | sat[l];
      end
      rsp_in.out_first_x = res[0];
      rsp_in.out_first_y = res[1];
      rsp_in.out_second_x = res[2];
      rsp_in.out_second_y = res[3];
      rsp_in.in_front = front_out;
      rsp_in.clipped = front_out && any_sat;
   end

   logic rsp_vld_ff;
   hsp_rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= ctl_ff[IN_BITS].vld;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_item = rsp_ff;

   // ---- checks ----
   `HSP_ASSERT_AFTER(a_latency, clock, reset, accept, LAT, rsp_strobe, "item lost in pipeline")
   `HSP_ASSERT_NOW(a_clip_front, clock, reset, rsp_strobe && rsp_item.clipped, rsp_item.in_front, "clipped while behind")
   `HSP_ASSERT_NOW(a_behind_zero, clock, reset, rsp_strobe && !rsp_item.in_front, (rsp_item.out_first_x == '0) && (rsp_item.out_second_y == '0), "nonzero behind")
endmodule
`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the segment projection block: random and directed
// segments under several matrices, checked in order against a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
   import hsp_pkg::*;

   localparam int IN_BITS = 32;
   localparam int LATENCY = IN_BITS + 5;

   // predicted-result store plus the matrix copy used to predict
   class proj_scoreboard;
      hsp_rsp_type pending[$];
      logic [63:0] pair_a, pair_b, pair_c, pair_d, last;
      int errors;

      function new();
         pair_a = COEF_ONE; pair_b = 0; pair_c = COEF_ONE; pair_d = 0;
         last = COEF_ONE; errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
         case (idx)
            CSR_PAIR_A: pair_a = val;
            CSR_PAIR_B: pair_b = val;
            CSR_PAIR_C: pair_c = val;
            CSR_PAIR_D: pair_d = val;
            CSR_LAST:   last = {32'd0, val[31:0]};
            default: ;
         endcase
      endfunction

      function logic signed [31:0] coef(int n);
         case (n)
            0: coef = pair_a[31:0];
            1: coef = pair_a[63:32];
            2: coef = pair_b[31:0];
            3: coef = pair_b[63:32];
            4: coef = pair_c[31:0];
            5: coef = pair_c[63:32];
            6: coef = pair_d[31:0];
            7: coef = pair_d[63:32];
            default: coef = last[31:0];
         endcase
      endfunction

      function logic signed [127:0] dot(int r, logic signed [31:0] x,
                                        logic signed [31:0] y, logic signed [31:0] w);
         logic signed [127:0] s;
         s = 128'(coef(r*3)) * 128'(x) + 128'(coef(r*3+1)) * 128'(y)
             + 128'(coef(r*3+2)) * 128'(w);
         return s;
      endfunction

      // exact (num << 16) / den toward zero, saturated to 32 bits
      function logic [31:0] quot(logic signed [127:0] num, logic signed [127:0] den,
                                 ref logic clip);
         logic neg;
         logic [127:0] mag, q, lim;
         neg = num[127];
         mag = neg ? -num : num;
         q = (mag << 16) / den;
         lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
         if (q > lim) begin
            clip = 1'b1;
            q = lim;
         end
         return neg ? -q[31:0] : q[31:0];
      endfunction

      function void note_item(hsp_req_type it);
         hsp_rsp_type r;
         logic signed [127:0] x0, y0, w0, x1, y1, w1;
         logic clip;
         x0 = dot(0, it.first_x, it.first_y, it.first_w);
         y0 = dot(1, it.first_x, it.first_y, it.first_w);
         w0 = dot(2, it.first_x, it.first_y, it.first_w);
         x1 = dot(0, it.second_x, it.second_y, it.second_w);
         y1 = dot(1, it.second_x, it.second_y, it.second_w);
         w1 = dot(2, it.second_x, it.second_y, it.second_w);
         r = '0;
         clip = 1'b0;
         if (w0 > 0 && w1 > 0) begin
            r.out_first_x = quot(x0, w0, clip);
            r.out_first_y = quot(y0, w0, clip);
            r.out_second_x = quot(x1, w1, clip);
            r.out_second_y = quot(y1, w1, clip);
            r.in_front = 1'b1;
            r.clipped = clip;
         end
         pending.insert(pending.size(), r);
      endfunction

      function void check_result(hsp_rsp_type got);
         hsp_rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.out_first_x !== e.out_first_x) begin
            $error("out_first_x exp %h got %h", e.out_first_x, got.out_first_x); errors++;
         end
         if (got.out_first_y !== e.out_first_y) begin
            $error("out_first_y exp %h got %h", e.out_first_y, got.out_first_y); errors++;
         end
         if (got.out_second_x !== e.out_second_x) begin
            $error("out_second_x exp %h got %h", e.out_second_x, got.out_second_x); errors++;
         end
         if (got.out_second_y !== e.out_second_y) begin
            $error("out_second_y exp %h got %h", e.out_second_y, got.out_second_y); errors++;
         end
         if (got.in_front !== e.in_front) begin
            $error("in_front exp %b got %b", e.in_front, got.in_front); errors++;
         end
         if (got.clipped !== e.clipped) begin
            $error("clipped exp %b got %b", e.clipped, got.clipped); errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   hsp_req_type req_item = '0;
   logic rsp_strobe;
   hsp_rsp_type rsp_item;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   proj_scoreboard sb = new();
   int idle_pct = 0;   // sender gap rate for the current phase

   homography_segment_projection_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // results cannot be held off; take each one on the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_item);
   end

   // item accept is start & !busy at the edge
   always @(posedge clock) begin
      if (!reset && start && !busy) sb.note_item(req_item);
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   // send one segment, random gap ahead of it; called at an edge, returns
   // at the accepting edge with start still high so items can follow back to back
   task automatic send_item(hsp_req_type it);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // block empties before any register write
   task automatic drain();
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(2 * 4096)) - 4096) << 12;
         default: return 32'h0001_0000 + 32'($urandom_range(8191)) - 32'd4096;
      endcase
   endfunction

   function automatic hsp_req_type rand_item();
      hsp_req_type it;
      int mode;
      mode = $urandom_range(9) < 2 ? 0 : 1;
      it.first_x = rand_coord(mode);
      it.first_y = rand_coord(mode);
      it.second_x = rand_coord(mode);
      it.second_y = rand_coord(mode);
      // weights near 1.0 mostly, so most segments land in front
      it.first_w = rand_coord($urandom_range(9) < 2 ? 0 : 2);
      it.second_w = rand_coord($urandom_range(9) < 2 ? 0 : 2);
      return it;
   endfunction

   function automatic logic [63:0] rand_pair();
      logic [31:0] lo, hi;
      lo = $urandom_range(3) == 0 ? $urandom() : 32'($signed($urandom_range(4194304)) - 2097152);
      hi = $urandom_range(3) == 0 ? $urandom() : 32'($signed($urandom_range(4194304)) - 2097152);
      return {hi, lo};
   endfunction

   task automatic random_matrix(int kind);
      logic [63:0] v [5];
      case (kind)
         0: begin   // identity
            v[0] = COEF_ONE; v[1] = 0; v[2] = COEF_ONE; v[3] = 0; v[4] = COEF_ONE;
         end
         1: begin   // extremes
            v[0] = 64'hFFFF_FFFF_8000_0000; v[1] = 64'h7FFF_FFFF_8000_0000;
            v[2] = 64'h8000_0000_7FFF_FFFF; v[3] = 64'h0;
            v[4] = 64'hFFFF_FFFF_7FFF_FFFF;
         end
         default: begin
            v[0] = rand_pair(); v[1] = rand_pair(); v[2] = rand_pair();
            // small perspective row, mostly; m22 near 1.0
            v[3] = {32'($signed($urandom_range(2048)) - 1024),
                    32'($signed($urandom_range(2048)) - 1024)};
            v[4] = {$urandom(), 32'h0010_0000 + 32'($urandom_range(65535))};
            if ($urandom_range(4) == 0) v[3] = rand_pair();
         end
      endcase
      for (int i = 0; i < 5; i++) write_reg(CSR_IDX_W'(i), v[i]);
      // index beyond the last register must not disturb anything
      write_reg(3'd5 + CSR_IDX_W'($urandom_range(2)), {$urandom(), $urandom()});
   endtask

   task automatic directed();
      hsp_req_type it;
      logic [31:0] ext [6];
      ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000,
              32'h0000_0001};
      // plain unit weights, extreme coordinates: overflow and saturation
      for (int i = 0; i < 6; i++) begin
         it = '{ext[i], ext[5 - i], 32'h0001_0000, ext[(i + 2) % 6], ext[i],
                32'h0001_0000};
         send_item(it);
      end
      // tiny weight forces clipping
      send_item('{32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h1, 32'hFFFF_FFFF, 32'h1});
      // zero weight, negative weight on either point (not in front), then two large positive weights
      send_item('{32'h0001_0000, 32'h0002_0000, 32'h0, 32'h1, 32'h1, 32'h0001_0000});
      send_item('{32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h1, 32'h1,
                  32'hFFFF_0000});
      send_item('{32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF});
      send_item('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'h7FFF_FFFF});
      // negative quotient at the low end
      send_item('{32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 32'h8000_0000,
                  32'h4000_0000, 32'h0000_8000});
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // reset matrix is the identity
      directed();
      drain();
      random_matrix(1);
      idle_pct = 21;
      directed();
      drain();
      for (int ph = 0; ph < 8; ph++) begin
         random_matrix(ph == 0 ? 0 : (ph == 7 ? 1 : 2));
         // sender idling: 21, then 59, then none
         idle_pct = ph < 3 ? 21 : (ph < 5 ? 59 : 0);
         for (int n = 0; n < 200; n++) begin
            send_item(rand_item());
            // one hold-off until the pipe is empty
            if (ph == 2 && n == 100) begin
               start <= 1'b0;
               while (sb.pending.size() != 0) @(posedge clock);
            end
         end
         drain();
      end
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
+incdir+src
src/hsp_pkg.sv
src/hsp_point_proj.sv
src/hsp_div_cell.sv
src/homography_segment_projection_top.sv
tb/sv/tb.sv
